// File: sv/mef_pkg.sv
// Package: types, constants and exp2 table for the multiband envelope follower.
package mef_pkg;
    localparam int unsigned BANDS_DEF = 8;
    localparam int unsigned REG_W = 24;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned DT_W = 21;
    localparam int unsigned ENV_W = 24;
    localparam int unsigned COEF_W = 17;
    localparam logic [REG_W-1:0] TAU_MIN = 24'd10;
    localparam logic [REG_W-1:0] ATTACK_RESET = 24'd10000;
    localparam logic [REG_W-1:0] RELEASE_RESET = 24'd200000;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [COEF_W-1:0] COEFF_ONE = 17'd65536;

    typedef enum logic [0:0] {
        REG_ATTACK  = 1'b0,
        REG_RELEASE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_HOLD  = 2'd1,
        OP_TRACK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_DIV   = 3'd1,
        ST_LOG   = 3'd2,
        ST_EXP   = 3'd3,
        ST_BANDS = 3'd4,
        ST_SUM   = 3'd5,
        ST_OUT   = 3'd6
    } t_state;

    function automatic logic [31:0] exp2_tab(input logic [3:0] n);
        logic [31:0] v;
        case (n)
            4'd0:    v = 32'd3037000500;
            4'd1:    v = 32'd3611622603;
            4'd2:    v = 32'd3938502376;
            4'd3:    v = 32'd4112874773;
            4'd4:    v = 32'd4202935003;
            4'd5:    v = 32'd4248701965;
            4'd6:    v = 32'd4271771997;
            4'd7:    v = 32'd4283353945;
            4'd8:    v = 32'd4289156690;
            4'd9:    v = 32'd4292061010;
            4'd10:   v = 32'd4293513907;
            4'd11:   v = 32'd4294240540;
            4'd12:   v = 32'd4294603903;
            4'd13:   v = 32'd4294785595;
            4'd14:   v = 32'd4294876445;
            default: v = 32'd4294921870;
        endcase
        return v;
    endfunction
endpackage

// File: sv/mef_front.sv
// Front end: input skid queue of two frames with operation classification.
module mef_front
    import mef_pkg::*;
#(
    parameter int unsigned BANDS = BANDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [BANDS*LEVEL_W-1:0]    i_levels,
    input  logic [DT_W-1:0]             i_dt,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [BANDS*LEVEL_W-1:0]    o_levels,
    output logic [DT_W-2:0]             o_dt,
    output t_op                         o_op
);
    logic [BANDS*LEVEL_W-1:0] r_lv [2];
    logic [DT_W-2:0]          r_dt [2];
    t_op                      r_op [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic                     push, pop;
    t_op                      op;

    always_comb begin
        if (i_dt[DT_W-1])
            op = OP_LOAD;
        else if (i_dt[DT_W-2:0] == '0)
            op = OP_HOLD;
        else
            op = OP_TRACK;
    end

    assign o_ready  = (r_cnt != 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign push     = i_valid && o_ready;
    assign pop      = o_valid && i_ready;
    assign o_levels = r_lv[r_rp];
    assign o_dt     = r_dt[r_rp];
    assign o_op     = r_op[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_lv[r_wp] <= i_levels;
            r_dt[r_wp] <= i_dt[DT_W-2:0];
            r_op[r_wp] <= op;
        end
    end
endmodule

// File: sv/mef_back.sv
// Back end: sequenced coefficient computation, band update and result register.
module mef_back
    import mef_pkg::*;
#(
    parameter int unsigned BANDS = BANDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [REG_W-1:0]            i_attack,
    input  logic [REG_W-1:0]            i_release,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [BANDS*LEVEL_W-1:0]    i_levels,
    input  logic [DT_W-2:0]             i_dt,
    input  t_op                         i_op,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [(BANDS+1)*LEVEL_W-1:0] o_data
);
    localparam int unsigned BW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int unsigned SUM_W = ENV_W + BW + 1;
    localparam int unsigned NUM_W = DT_W - 1 + 16;

    t_state r_state, n_state;
    logic [ENV_W-1:0]         r_env [BANDS];
    logic [BANDS*LEVEL_W-1:0] r_lv;
    logic [DT_W-2:0]          r_dt;
    logic                     r_sel;
    logic [REG_W-1:0]         r_tau;
    logic [NUM_W-1:0]         r_q;
    logic [REG_W:0]           r_rem;
    logic [5:0]               r_cnt;
    logic [35:0]              r_y;
    logic [32:0]              r_p;
    logic [COEF_W-1:0]        r_att, r_rel;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_ovalid;
    logic [(BANDS+1)*LEVEL_W-1:0] r_out;

    logic [REG_W:0]  rem_sh;
    logic [REG_W:0]  rem_sub;
    logic [63:0]     pmul;
    logic [BW-1:0]   bi;
    logic [ENV_W-1:0] tgt, env_cur, diff;
    logic [ENV_W+COEF_W-1:0] prod;
    logic [ENV_W-1:0] env_new;
    logic [COEF_W-1:0] bcoef;
    logic             rise;
    logic             take;

    // final exp step folded with shift and round
    function automatic logic [16:0] e16p(input logic [32:0] p, input logic [35:0] y,
                                         input logic [63:0] pm);
        logic [32:0] pf;
        logic [32:0] ee;
        pf = y[0] ? {1'b0, pm[63:32]} : p;
        ee = pf >> y[35:16];
        return 17'((ee + 33'h8000) >> 16);
    endfunction

    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // restoring divider step
    assign rem_sh  = {r_rem[REG_W-1:0], r_q[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_tau};
    // p = 1.0 multiplies to the table entry itself
    assign pmul    = r_p[32] ? {exp2_tab(r_cnt[3:0]), 32'd0}
                             : (r_p[31:0] * exp2_tab(r_cnt[3:0]));

    assign bi      = r_cnt[BW-1:0];
    assign tgt     = {r_lv[bi*LEVEL_W +: LEVEL_W], 8'd0};
    assign env_cur = r_env[bi];
    assign rise    = (tgt >= env_cur);
    assign diff    = rise ? (tgt - env_cur) : (env_cur - tgt);
    assign bcoef   = rise ? r_att : r_rel;
    assign prod    = diff * bcoef;
    assign env_new = rise ? (env_cur + prod[ENV_W+15:16]) : (env_cur - prod[ENV_W+15:16]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (take) begin
                if (i_op == OP_TRACK) n_state = ST_DIV;
                else if (i_op == OP_LOAD) n_state = ST_SUM;
                else n_state = ST_SUM;
            end
            ST_DIV:   if (r_cnt == 6'(NUM_W - 1)) n_state = ST_LOG;
            ST_LOG:   n_state = (r_q >= NUM_W'(32'h100000)) ? (r_sel ? ST_BANDS : ST_DIV)
                                                           : ST_EXP;
            ST_EXP:   if (r_cnt == 6'd15) n_state = r_sel ? ST_BANDS : ST_DIV;
            ST_BANDS: if (r_cnt == 6'(BANDS - 1)) n_state = ST_SUM;
            ST_SUM:   if (r_cnt == 6'(BANDS - 1)) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            for (int k = 0; k < BANDS; k++) r_env[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: if (take) begin
                    r_lv  <= i_levels;
                    r_dt  <= i_dt;
                    r_sel <= 1'b0;
                    r_cnt <= '0;
                    r_sum <= '0;
                    r_tau <= (i_attack < TAU_MIN) ? TAU_MIN : i_attack;
                    r_q   <= {i_dt, 16'd0};
                    r_rem <= '0;
                    if (i_op == OP_LOAD)
                        for (int k = 0; k < BANDS; k++)
                            r_env[k] <= {i_levels[k*LEVEL_W +: LEVEL_W], 8'd0};
                end
                ST_DIV: begin
                    r_rem <= rem_sub[REG_W] ? rem_sh : rem_sub;
                    r_q   <= {r_q[NUM_W-2:0], ~rem_sub[REG_W]};
                    r_cnt <= (r_cnt == 6'(NUM_W - 1)) ? '0 : r_cnt + 6'd1;
                end
                ST_LOG: begin
                    r_y   <= 36'((53'(r_q) * 53'(LOG2E_Q16)) >> 16);
                    r_p   <= 33'h1_0000_0000;
                    r_cnt <= '0;
                    if (r_q >= NUM_W'(32'h100000)) begin
                        if (r_sel) r_rel <= COEFF_ONE;
                        else r_att <= COEFF_ONE;
                        r_sel <= 1'b1;
                        r_tau <= (i_release < TAU_MIN) ? TAU_MIN : i_release;
                        r_q   <= {r_dt, 16'd0};
                        r_rem <= '0;
                    end
                end
                ST_EXP: begin
                    if (r_y[15 - r_cnt[3:0]]) r_p <= {1'b0, pmul[63:32]};
                    r_cnt <= (r_cnt == 6'd15) ? '0 : r_cnt + 6'd1;
                end
                ST_BANDS: begin
                    r_env[bi] <= env_new;
                    r_cnt <= (r_cnt == 6'(BANDS - 1)) ? '0 : r_cnt + 6'd1;
                end
                ST_SUM: begin
                    r_sum <= r_sum + SUM_W'(env_cur);
                    r_out[bi*LEVEL_W +: LEVEL_W] <= env_cur[ENV_W-1:8];
                    r_cnt <= (r_cnt == 6'(BANDS - 1)) ? '0 : r_cnt + 6'd1;
                end
                ST_OUT: begin
                    r_out[BANDS*LEVEL_W +: LEVEL_W] <= LEVEL_W'(r_sum / (BANDS * 256));
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == ST_EXP && r_cnt == 6'd15) begin
                if (r_sel) r_rel <= 17'(COEFF_ONE - e16p(r_p, r_y, pmul));
                else r_att <= 17'(COEFF_ONE - e16p(r_p, r_y, pmul));
                r_sel <= 1'b1;
                r_tau <= (i_release < TAU_MIN) ? TAU_MIN : i_release;
                r_q   <= {r_dt, 16'd0};
                r_rem <= '0;
            end
        end
    end
endmodule

// File: sv/multiband_envelope_follower.sv
// Top level: multiband attack/release envelope follower.
//  channel | dir | handshake            | word
//  s_axis  | in  | tvalid/tready        | levels 0..N-1, frame_interval_us
//  m_axis  | out | tvalid/tready        | envelopes 0..N-1, overall_level
//  cfg     | in  | i_cfg_we             | index 0 attack, 1 release
// Load/hold frame: goes straight to the sum and result states; tracking frame: the
// bit-serial divider and serial exp2 multiplier run for each time constant, then the bands update
// (the exp2 step is skipped for a time constant whose coefficient saturates at one).
// The back end can take the next word in the cycle after its result is accepted.
// Synchronous active-low reset clears envelopes and restores default time constants.
// A two-word input queue accepts while a result waits on m_axis.
module multiband_envelope_follower
    import mef_pkg::*;
#(
    parameter int unsigned BANDS = BANDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // level_0..level_N-1, frame_interval_us, zero pad
    input  logic [((BANDS*LEVEL_W+DT_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // envelope_0..envelope_N-1, overall_level
    output logic [(BANDS+1)*LEVEL_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [REG_W-1:0]              i_cfg_data
);
    logic [REG_W-1:0] r_attack, r_release;
    logic q_valid, q_ready;
    logic [BANDS*LEVEL_W-1:0] q_lv;
    logic [DT_W-2:0] q_dt;
    t_op q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_RESET;
            r_release <= RELEASE_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ATTACK:  r_attack  <= i_cfg_data;
                REG_RELEASE: r_release <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mef_front #(.BANDS(BANDS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_levels(s_axis_tdata[BANDS*LEVEL_W-1:0]),
        .i_dt(s_axis_tdata[BANDS*LEVEL_W +: DT_W]),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_levels(q_lv), .o_dt(q_dt), .o_op(q_op)
    );

    mef_back #(.BANDS(BANDS)) u_back (
        .i_clk, .i_rst_n,
        .i_attack(r_attack), .i_release(r_release),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_levels(q_lv), .i_dt(q_dt), .i_op(q_op),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && t_reg_idx'(i_cfg_idx) == REG_ATTACK |=> r_attack == $past(i_cfg_data))
        else $error("attack register not written");
    a_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_ready |=> q_valid)
        else $error("queue lost a word");
endmodule
